@@ design/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, constants and the modular double-and-add step for the
// binomial coefficient mod prime block.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int MOD_W         = 31;
  localparam int CNT_W         = 10;
  localparam int MAX_N_DEFAULT = 1023;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
  localparam logic [4:0] STEP_LAST = 5'(MOD_W - 1);

  typedef enum logic [3:0] {
    B_INIT,
    B_ONE,
    B_DIV,
    B_RD,
    B_LD,
    B_MINV,
    B_MIFACT,
    B_MFACT,
    B_DONE
  } build_state_t;

  typedef struct packed {
    logic fact_we;
    logic ifact_we;
  } tbl_wr_t;

  // One bit of a*b mod p, most significant bit of a first.
  // Needs acc < p and b <= p.
  function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] acc,
                                                input logic [MOD_W-1:0] b,
                                                input logic [MOD_W-1:0] p,
                                                input logic             abit);
    logic [MOD_W:0]   t;
    logic [MOD_W+1:0] u;
    t = {acc, 1'b0};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    u = {1'b0, t} + (abit ? {2'b00, b} : '0);
    if (u >= {2'b00, p}) u = u - {2'b00, p};
    return u[MOD_W-1:0];
  endfunction

endpackage

@@ design/bmp_ifs.sv @@
// ----------------------------------------------------------------------------
// bmp channel interfaces
// Query, result and modulus write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bmp_query_if;
  logic                       valid;
  logic                       ready;
  logic [bmp_pkg::CNT_W-1:0]  total_count;
  logic [bmp_pkg::CNT_W-1:0]  choose_count;
  modport source (output valid, total_count, choose_count, input ready);
  modport sink   (input valid, total_count, choose_count, output ready);
endinterface

interface bmp_result_if;
  logic                       valid;
  logic                       ready;
  logic [bmp_pkg::MOD_W-1:0]  coefficient;
  logic                       out_of_range;
  modport source (output valid, coefficient, out_of_range, input ready);
  modport sink   (input valid, coefficient, out_of_range, output ready);
endinterface

interface bmp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bmp_pkg::MOD_W-1:0]  modulus;
  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

@@ design/bmp_build.sv @@
// ----------------------------------------------------------------------------
// bmp_build
// Table build sequencer: serial divider and serial modular multiplier that
// fill the inverse, inverse factorial and factorial tables for one modulus.
// ----------------------------------------------------------------------------
module bmp_build #(
  parameter int MAX_N = bmp_pkg::MAX_N_DEFAULT,
  localparam int AW   = $clog2(MAX_N + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic [bmp_pkg::MOD_W-1:0] modulus,
  output logic                      done,
  output bmp_pkg::tbl_wr_t          tbl_wr,
  output logic [AW-1:0]             wr_addr,
  output logic [bmp_pkg::MOD_W-1:0] wr_data
);

  localparam int W = bmp_pkg::MOD_W;

  bmp_pkg::build_state_t state_r, state_nxt;

  logic [AW-1:0] i_r;
  logic [W-1:0]  ri_r;
  logic [4:0]    cnt_r;
  logic [W-1:0]  acc_r, ma_r, mb_r;
  logic [W-1:0]  dq_r;
  logic [AW-1:0] rem_r;
  logic [W-1:0]  fact_prev_r, ifact_prev_r;
  logic [W-1:0]  inv_mem [0:MAX_N];
  logic [W-1:0]  inv_rd_r;

  logic          inv_we;
  logic [W-1:0]  one;
  logic [W-1:0]  step_res, mul_res;
  logic          last_step;
  logic [AW:0]   r2, r2n;
  logic          ge;
  logic [W:0]    ri_p1;
  logic [W-1:0]  ri_inc;
  logic          last_i;

  assign one       = (modulus > W'(1)) ? W'(1) : '0;
  assign step_res  = bmp_pkg::mod_step(acc_r, mb_r, modulus, ma_r[W-1]);
  assign mul_res   = (modulus == '0) ? '0 : step_res;
  assign last_step = (cnt_r == '0);
  assign r2        = {rem_r, dq_r[W-1]};
  assign ge        = (r2 >= {1'b0, i_r});
  assign r2n       = ge ? (r2 - {1'b0, i_r}) : r2;
  assign ri_p1     = {1'b0, ri_r} + (W+1)'(1);
  assign ri_inc    = (ri_p1 == {1'b0, modulus}) ? '0 : ri_p1[W-1:0];
  assign last_i    = (i_r == AW'(MAX_N));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmp_pkg::B_INIT:   state_nxt = bmp_pkg::B_ONE;
      bmp_pkg::B_ONE:    state_nxt = bmp_pkg::B_MFACT;
      bmp_pkg::B_DIV:    if (last_step) state_nxt = bmp_pkg::B_RD;
      bmp_pkg::B_RD:     state_nxt = bmp_pkg::B_LD;
      bmp_pkg::B_LD:     state_nxt = bmp_pkg::B_MINV;
      bmp_pkg::B_MINV:   if (last_step) state_nxt = bmp_pkg::B_MIFACT;
      bmp_pkg::B_MIFACT: if (last_step) state_nxt = bmp_pkg::B_MFACT;
      bmp_pkg::B_MFACT:  if (last_step) state_nxt = last_i ? bmp_pkg::B_DONE : bmp_pkg::B_DIV;
      bmp_pkg::B_DONE:   state_nxt = bmp_pkg::B_DONE;
      default:           state_nxt = bmp_pkg::B_INIT;
    endcase
    if (restart) state_nxt = bmp_pkg::B_INIT;
  end

  // outputs
  always_comb begin
    inv_we          = 1'b0;
    tbl_wr.fact_we  = 1'b0;
    tbl_wr.ifact_we = 1'b0;
    wr_addr         = i_r;
    wr_data         = mul_res;
    done            = 1'b0;
    unique case (state_r)
      bmp_pkg::B_INIT: begin
        inv_we          = 1'b1;
        tbl_wr.fact_we  = 1'b1;
        tbl_wr.ifact_we = 1'b1;
        wr_addr         = '0;
        wr_data         = one;
      end
      bmp_pkg::B_ONE: begin
        inv_we          = 1'b1;
        tbl_wr.ifact_we = 1'b1;
        wr_data         = one;
      end
      bmp_pkg::B_MINV:   inv_we          = last_step;
      bmp_pkg::B_MIFACT: tbl_wr.ifact_we = last_step;
      bmp_pkg::B_MFACT:  tbl_wr.fact_we  = last_step;
      bmp_pkg::B_DONE:   done            = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmp_pkg::B_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (inv_we) inv_mem[wr_addr] <= wr_data;
    inv_rd_r <= inv_mem[rem_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bmp_pkg::B_INIT: begin
        i_r          <= AW'(1);
        ri_r         <= one;
        fact_prev_r  <= one;
        ifact_prev_r <= one;
      end
      bmp_pkg::B_ONE: begin
        acc_r <= '0;
        ma_r  <= fact_prev_r;
        mb_r  <= ri_r;
        cnt_r <= bmp_pkg::STEP_LAST;
      end
      bmp_pkg::B_DIV: begin
        dq_r  <= {dq_r[W-2:0], ge};
        rem_r <= r2n[AW-1:0];
        cnt_r <= cnt_r - 5'd1;
      end
      bmp_pkg::B_LD: begin
        acc_r <= '0;
        ma_r  <= inv_rd_r;
        mb_r  <= modulus - dq_r;
        cnt_r <= bmp_pkg::STEP_LAST;
      end
      bmp_pkg::B_MINV, bmp_pkg::B_MIFACT, bmp_pkg::B_MFACT: begin
        if (!last_step) begin
          acc_r <= step_res;
          ma_r  <= {ma_r[W-2:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
        end else begin
          acc_r <= '0;
          cnt_r <= bmp_pkg::STEP_LAST;
          if (state_r == bmp_pkg::B_MINV) begin
            ma_r <= mul_res;
            mb_r <= ifact_prev_r;
          end else if (state_r == bmp_pkg::B_MIFACT) begin
            ifact_prev_r <= mul_res;
            ma_r         <= fact_prev_r;
            mb_r         <= ri_r;
          end else begin
            // advance to the next index and start its division
            fact_prev_r <= mul_res;
            i_r         <= i_r + AW'(1);
            ri_r        <= ri_inc;
            dq_r        <= modulus;
            rem_r       <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/binomial_mod_prime_top.sv @@
// Query path: the table read register is loaded at the input transfer edge, then
// 31 + 31 double-and-add stages and the output register lead to out_ch.valid.
// Throughput: one query per cycle; the pipeline stalls only when its last
// stage and the output register are both full and out_ch.ready is low.
// Reset and every modulus write rebuild the tables; in_ch.ready stays low
// while the serial divider and multiplier run.
// ----------------------------------------------------------------------------
// binomial_mod_prime_top
// C(n, r) mod p from factorial and inverse factorial tables.
// ----------------------------------------------------------------------------
module binomial_mod_prime_top #(
  parameter int MAX_N = bmp_pkg::MAX_N_DEFAULT
) (
  input  logic   clk,
  input  logic   rst_n,
  bmp_query_if.sink   in_ch,
  bmp_result_if.source out_ch,
  bmp_cfg_if.sink     cfg_ch
);

  localparam int W   = bmp_pkg::MOD_W;
  localparam int AW  = $clog2(MAX_N + 1);
  localparam int NST = 2 * W;

  logic [W-1:0]      modulus_r;
  logic              cfg_wr;
  logic              built;
  bmp_pkg::tbl_wr_t  tbl_wr;
  logic [AW-1:0]     wr_addr;
  logic [W-1:0]      wr_data;

  logic [W-1:0]      fact_mem  [0:MAX_N];
  logic [W-1:0]      ifact_mem [0:MAX_N];

  logic              adv, in_xfer, in_oor;
  logic [bmp_pkg::CNT_W-1:0] nr;

  logic              s0_v_r, s0_oor_r;
  logic [W-1:0]      fact_q_r, ifr_q_r, ifnr_q_r;

  logic              pv_r  [1:NST];
  logic              oor_r [1:NST];
  logic [W-1:0]      acc_r [1:NST];
  logic [W-1:0]      ash_r [1:NST];
  logic [W-1:0]      bop_r [1:NST];
  logic [W-1:0]      cop_r [1:NST];

  logic              out_valid_r;
  logic [W-1:0]      out_coef_r;
  logic              out_oor_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= bmp_pkg::MODULUS_RESET;
    end else if (cfg_wr) begin
      modulus_r <= cfg_ch.modulus;
    end
  end

  bmp_build #(.MAX_N(MAX_N)) u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .modulus (modulus_r),
    .done    (built),
    .tbl_wr  (tbl_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // hold the whole pipeline only when its last stage cannot drain
  assign adv         = !(pv_r[NST] && out_valid_r && !out_ch.ready);
  assign in_ch.ready = built && adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign nr          = in_ch.total_count - in_ch.choose_count;
  assign in_oor      = (17'(in_ch.total_count) > 17'(MAX_N)) ||
                       (in_ch.choose_count > in_ch.total_count);

  always_ff @(posedge clk) begin
    if (tbl_wr.fact_we)  fact_mem[wr_addr]  <= wr_data;
    if (tbl_wr.ifact_we) ifact_mem[wr_addr] <= wr_data;
    if (adv) begin
      fact_q_r <= fact_mem[AW'(in_ch.total_count)];
      ifr_q_r  <= ifact_mem[AW'(in_ch.choose_count)];
      ifnr_q_r <= ifact_mem[AW'(nr)];
      s0_oor_r <= in_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      for (int k = 1; k <= NST; k++) pv_r[k] <= 1'b0;
    end else if (adv) begin
      s0_v_r  <= in_xfer;
      pv_r[1] <= s0_v_r;
      for (int k = 2; k <= NST; k++) pv_r[k] <= pv_r[k-1];
    end
  end

  // first product fact[n]*invfact[r], second times invfact[n-r]
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r[1] <= bmp_pkg::mod_step('0, ifr_q_r, modulus_r, fact_q_r[W-1]);
      ash_r[1] <= {fact_q_r[W-2:0], 1'b0};
      bop_r[1] <= ifr_q_r;
      cop_r[1] <= ifnr_q_r;
      oor_r[1] <= s0_oor_r;
      for (int k = 2; k <= NST; k++) begin
        oor_r[k] <= oor_r[k-1];
        cop_r[k] <= cop_r[k-1];
        if (k == W + 1) begin
          acc_r[k] <= bmp_pkg::mod_step('0, cop_r[k-1], modulus_r, acc_r[k-1][W-1]);
          ash_r[k] <= {acc_r[k-1][W-2:0], 1'b0};
          bop_r[k] <= cop_r[k-1];
        end else begin
          acc_r[k] <= bmp_pkg::mod_step(acc_r[k-1], bop_r[k-1], modulus_r,
                                        ash_r[k-1][W-1]);
          ash_r[k] <= {ash_r[k-1][W-2:0], 1'b0};
          bop_r[k] <= bop_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && pv_r[NST]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pv_r[NST]) begin
      out_coef_r <= (oor_r[NST] || modulus_r == '0) ? '0 : acc_r[NST];
      out_oor_r  <= oor_r[NST];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coefficient  = out_coef_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

@@ design/bmp_checker.sv @@
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks on the binomial block, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bmp_pkg::MOD_W-1:0] coefficient,
  input logic                      out_of_range,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(coefficient) && $stable(out_of_range))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> coefficient == '0)
    else $error("out of range result is not zero");

  a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("queries taken right after a modulus write");

endmodule

bind binomial_mod_prime_top bmp_checker u_bmp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .coefficient  (out_ch.coefficient),
  .out_of_range (out_ch.out_of_range),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready)
);
